// File: rtl/ipsg_pkg.sv
// ============================================================================
// ipsg_pkg
// Shared constants, codes and types of the IP source guard.
// ============================================================================
package ipsg_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int PORT_COUNT    = 64;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = IDX_W + 1;

    // Action codes.
    localparam logic [2:0] ACT_CHECK      = 3'd0;
    localparam logic [2:0] ACT_WRITE      = 3'd1;
    localparam logic [2:0] ACT_REMOVE     = 3'd2;
    localparam logic [2:0] ACT_READ_CNT   = 3'd3;
    localparam logic [2:0] ACT_READ_BIND  = 3'd4;

    // Verdict codes.
    localparam logic [1:0] VERDICT_CONTINUE = 2'd0;
    localparam logic [1:0] VERDICT_PARSE    = 2'd1;
    localparam logic [1:0] VERDICT_BLOCKED  = 2'd2;

    // Operation status codes.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

    // Statistics counter indexes.
    localparam int CNT_TOTAL  = 0;
    localparam int CNT_PASSED = 1;
    localparam int CNT_MAC    = 2;
    localparam int CNT_PORT   = 3;

    // Configuration register indexes.
    localparam logic [2:0] CFG_GUARD_EN  = 3'd0;
    localparam logic [2:0] CFG_STRICT    = 3'd1;
    localparam logic [2:0] CFG_MAC_CHK   = 3'd2;
    localparam logic [2:0] CFG_PORT_CHK  = 3'd3;
    localparam logic [2:0] CFG_PORT_MASK = 3'd4;

    // One binding table row as held in memory.
    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
        logic [5:0]  port;
        logic [63:0] violations;
        logic [63:0] last_seen;
    } row_t;

    localparam int ROW_W = $bits(row_t);

endpackage

// File: rtl/ipsg_ram.sv
// ============================================================================
// ipsg_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ============================================================================
module ipsg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        aclk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/ip_mac_port_source_guard.sv
// ============================================================================
// ip_mac_port_source_guard
// IP source guard: binds source IPv4 addresses to a MAC and ingress port.
// ============================================================================
// One transaction is processed at a time: the input is accepted only in the
// idle state, the binding table is then scanned linearly through the single
// read port of its RAM, and the result is registered once the output
// register is free or being taken; the next transaction is accepted only
// after the sequencer has returned to idle.
// Reset: synchronous, active low; clears the valid bits of all bindings,
// the statistics counters and the configuration; table contents persist.

module ip_mac_port_source_guard (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_wdata,
    // Input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_action,
    input  logic [31:0] s_src_ip,
    input  logic [47:0] s_src_mac,
    input  logic [5:0]  s_port,
    input  logic        s_is_ipv4,
    input  logic        s_frame_short,
    input  logic [63:0] s_now_ns,
    input  logic [1:0]  s_counter_index,
    // Result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_verdict,
    output logic        m_event_valid,
    output logic        m_mac_mismatch,
    output logic        m_port_mismatch,
    output logic [47:0] m_bound_mac,
    output logic [5:0]  m_expected_port,
    output logic [1:0]  m_op_status,
    output logic [63:0] m_read_value,
    output logic [63:0] m_read_last_seen
);

    import ipsg_pkg::*;

    // Sequencer states.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EXEC = 2'd2;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic        guard_en_reg;
    logic        strict_reg;
    logic        mac_chk_reg;
    logic        port_chk_reg;
    logic [63:0] port_mask_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            guard_en_reg  <= 1'b0;
            strict_reg    <= 1'b0;
            mac_chk_reg   <= 1'b0;
            port_chk_reg  <= 1'b0;
            port_mask_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_GUARD_EN:  guard_en_reg  <= cfg_wdata[0];
                CFG_STRICT:    strict_reg    <= cfg_wdata[0];
                CFG_MAC_CHK:   mac_chk_reg   <= cfg_wdata[0];
                CFG_PORT_CHK:  port_chk_reg  <= cfg_wdata[0];
                CFG_PORT_MASK: port_mask_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Captured input transaction.
    // ------------------------------------------------------------------
    logic [2:0]  act_reg;
    logic [31:0] ip_reg;
    logic [47:0] mac_reg;
    logic [5:0]  port_reg;
    logic        ipv4_reg;
    logic        short_reg;
    logic [63:0] now_reg;
    logic [1:0]  cidx_reg;

    logic [1:0]  state_reg, state_next;
    logic        s_fire;
    logic        exec_fire;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            act_reg   <= s_action;
            ip_reg    <= s_src_ip;
            mac_reg   <= s_src_mac;
            port_reg  <= s_port;
            ipv4_reg  <= s_is_ipv4;
            short_reg <= s_frame_short;
            now_reg   <= s_now_ns;
            cidx_reg  <= s_counter_index;
        end
    end

    // ------------------------------------------------------------------
    // Binding table: row contents in RAM, valid bits in flip-flops so that
    // reset empties the table at once.
    // ------------------------------------------------------------------
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic                     ram_we;
    logic [IDX_W-1:0]         ram_waddr;
    row_t                     ram_wrow;
    logic [IDX_W-1:0]         ram_raddr;
    logic [ROW_W-1:0]         ram_rdata;
    row_t                     rd_row;

    ipsg_ram #(
        .WIDTH (ROW_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wrow),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_row = row_t'(ram_rdata);

    // ------------------------------------------------------------------
    // Table scan. The counter issues one read per cycle; the returned row
    // is compared in the next cycle against the captured key. The first
    // matching valid row and the lowest free slot are remembered.
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] scan_cnt_reg;
    logic             scan_issue;
    logic             rd_vld_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic             hit_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    row_t             hit_row_reg;
    logic             free_reg;
    logic [IDX_W-1:0] free_idx_reg;

    assign scan_issue = (state_reg == ST_SCAN) &&
                        (scan_cnt_reg != CNT_W'(TABLE_ENTRIES));
    assign ram_raddr  = scan_cnt_reg[IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_cnt_reg <= '0;
            rd_vld_reg   <= 1'b0;
            hit_reg      <= 1'b0;
            free_reg     <= 1'b0;
        end else begin
            rd_vld_reg <= scan_issue;
            if (s_fire) begin
                scan_cnt_reg <= '0;
                hit_reg      <= 1'b0;
                free_reg     <= 1'b0;
            end else begin
                if (scan_issue) begin
                    scan_cnt_reg <= scan_cnt_reg + CNT_W'(1);
                end
                if (rd_vld_reg) begin
                    if (valid_reg[rd_idx_reg] && rd_row.ip == ip_reg && !hit_reg) begin
                        hit_reg <= 1'b1;
                    end
                    if (!valid_reg[rd_idx_reg] && !free_reg) begin
                        free_reg <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg <= ram_raddr;
        if (rd_vld_reg && valid_reg[rd_idx_reg] && rd_row.ip == ip_reg && !hit_reg) begin
            hit_idx_reg <= rd_idx_reg;
            hit_row_reg <= rd_row;
        end
        if (rd_vld_reg && !valid_reg[rd_idx_reg] && !free_reg) begin
            free_idx_reg <= rd_idx_reg;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    logic m_valid_reg;

    assign exec_fire = (state_reg == ST_EXEC) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_fire) state_next = ST_SCAN;
            ST_SCAN: begin
                if (!scan_issue && !rd_vld_reg) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: if (exec_fire) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Execution: judge the packet or carry out the control action, then
    // write back the row, valid bit and counters in the same cycle as the
    // result is loaded into the output register.
    // ------------------------------------------------------------------
    logic [63:0] stat_reg [4];
    logic [3:0]  stat_inc;
    logic        valid_set;
    logic        valid_clr;
    logic        guarded;
    logic        mv;
    logic        pv;

    logic [1:0]  verdict_next;
    logic        event_next;
    logic        macv_next;
    logic        portv_next;
    logic [47:0] exp_mac_next;
    logic [5:0]  exp_port_next;
    logic [1:0]  status_next;
    logic [63:0] rd_value_next;
    logic [63:0] rd_last_next;

    always_comb begin
        verdict_next  = VERDICT_CONTINUE;
        event_next    = 1'b0;
        macv_next     = 1'b0;
        portv_next    = 1'b0;
        exp_mac_next  = '0;
        exp_port_next = '0;
        status_next   = STATUS_OK;
        rd_value_next = '0;
        rd_last_next  = '0;
        stat_inc      = '0;
        ram_we        = 1'b0;
        ram_waddr     = hit_idx_reg;
        ram_wrow      = hit_row_reg;
        valid_set     = 1'b0;
        valid_clr     = 1'b0;

        guarded = guard_en_reg && ipv4_reg &&
                  ({1'b0, port_reg} < 7'(PORT_COUNT)) && port_mask_reg[port_reg];
        mv = mac_chk_reg && (mac_reg != hit_row_reg.mac);
        pv = port_chk_reg && (hit_row_reg.port != 6'd0) && (hit_row_reg.port != port_reg);

        unique case (act_reg)
            ACT_CHECK: begin
                if (guarded) begin
                    if (short_reg) begin
                        verdict_next = VERDICT_PARSE;
                    end else begin
                        stat_inc[CNT_TOTAL] = 1'b1;
                        if (!hit_reg) begin
                            if (strict_reg) begin
                                stat_inc[CNT_MAC] = 1'b1;
                                verdict_next      = VERDICT_BLOCKED;
                                event_next        = 1'b1;
                                macv_next         = 1'b1;
                            end
                        end else if (mv || pv) begin
                            stat_inc[CNT_MAC]   = mv;
                            stat_inc[CNT_PORT]  = pv;
                            ram_we              = 1'b1;
                            ram_wrow.violations = hit_row_reg.violations + 64'd1;
                            ram_wrow.last_seen  = now_reg;
                            verdict_next  = strict_reg ? VERDICT_BLOCKED : VERDICT_CONTINUE;
                            event_next    = 1'b1;
                            macv_next     = mv;
                            portv_next    = pv;
                            exp_mac_next  = hit_row_reg.mac;
                            exp_port_next = hit_row_reg.port;
                        end else begin
                            stat_inc[CNT_PASSED] = 1'b1;
                            ram_we               = 1'b1;
                            ram_wrow.last_seen   = now_reg;
                        end
                    end
                end
            end
            ACT_WRITE: begin
                if (hit_reg || free_reg) begin
                    ram_we              = 1'b1;
                    valid_set           = 1'b1;
                    ram_waddr           = hit_reg ? hit_idx_reg : free_idx_reg;
                    ram_wrow.ip         = ip_reg;
                    ram_wrow.mac        = mac_reg;
                    ram_wrow.port       = port_reg;
                    ram_wrow.violations = '0;
                    ram_wrow.last_seen  = '0;
                end else begin
                    status_next = STATUS_FULL;
                end
            end
            ACT_REMOVE: begin
                if (hit_reg) begin
                    valid_clr = 1'b1;
                end else begin
                    status_next = STATUS_NOT_FOUND;
                end
            end
            ACT_READ_CNT: begin
                rd_value_next = stat_reg[cidx_reg];
            end
            ACT_READ_BIND: begin
                if (hit_reg) begin
                    exp_mac_next  = hit_row_reg.mac;
                    exp_port_next = hit_row_reg.port;
                    rd_value_next = hit_row_reg.violations;
                    rd_last_next  = hit_row_reg.last_seen;
                end else begin
                    status_next = STATUS_NOT_FOUND;
                end
            end
            default: ;
        endcase

        ram_we = ram_we && exec_fire;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            for (int i = 0; i < 4; i++) begin
                stat_reg[i] <= '0;
            end
        end else if (exec_fire) begin
            if (valid_set) begin
                valid_reg[ram_waddr] <= 1'b1;
            end
            if (valid_clr) begin
                valid_reg[hit_idx_reg] <= 1'b0;
            end
            for (int i = 0; i < 4; i++) begin
                if (stat_inc[i]) begin
                    stat_reg[i] <= stat_reg[i] + 64'd1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register. It holds a finished transaction until it is taken.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (exec_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec_fire) begin
            m_verdict        <= verdict_next;
            m_event_valid    <= event_next;
            m_mac_mismatch   <= macv_next;
            m_port_mismatch  <= portv_next;
            m_bound_mac      <= exp_mac_next;
            m_expected_port  <= exp_port_next;
            m_op_status      <= status_next;
            m_read_value     <= rd_value_next;
            m_read_last_seen <= rd_last_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule
